// ===== src/gmps_pkg.sv =====
// ----------------------------------------------------------------------------
// gmps_pkg: shared constants and types
// Grid sizes, memory widths, heap entry layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package gmps_pkg;

	localparam int MAX_ROWS   = 128;
	localparam int MAX_COLS   = 128;
	localparam int COST_WIDTH = 16;
	localparam int SUM_W      = 30;
	localparam int CFG_W      = 8;

	localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	localparam int CELLS  = MAX_ROWS * MAX_COLS;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_W  = $clog2(CELLS + 1);

	localparam int HEAP_DEPTH = 4 * CELLS + 1;
	localparam int HADDR_W    = $clog2(HEAP_DEPTH);
	localparam int HCNT_W     = $clog2(HEAP_DEPTH + 1);

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	typedef struct packed {
		logic [SUM_W-1:0]  key;
		logic [CELL_W-1:0] idx;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} entry_t;

	typedef struct packed {
		logic             seen;
		logic [SUM_W-1:0] sum;
	} best_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_INIT,
		ST_SEED,
		ST_POP0,
		ST_POP1,
		ST_POP2,
		ST_SIFT_L,
		ST_SIFT_R,
		ST_SIFT_C,
		ST_CHECK,
		ST_EXPAND,
		ST_NB,
		ST_RELAX,
		ST_UP,
		ST_UP_C,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== src/gmps_ram.sv =====
// ----------------------------------------------------------------------------
// gmps_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data.
// ----------------------------------------------------------------------------
`default_nettype none
module gmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output      logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/grid_min_path_sum.sv =====
// ----------------------------------------------------------------------------
// grid_min_path_sum: cheapest four-neighbor path through a cost grid
// Loads cell costs, then runs a heap-based shortest path search in RAM.
// ----------------------------------------------------------------------------
// channel  ports                             timing
// cfg      cfg_we, cfg_index, cfg_data       written at any edge with cfg_we
// input    start, busy, cell_cost, last_cell item taken when start && !busy
// result   done, path_sum                    one cycle strobe, never stalled
//
// Items up to rows*cols are written to the cost RAM as taken. The item marked last
// starts a search: a clearing sweep over rows*cols best-cost RAM entries, then
// SIFT_L, SIFT_R, SIFT_C per heap level per pop and UP, UP_C per level per push,
// all through the single read port of the heap RAM. busy rises the cycle after
// the last item and falls the cycle after done. Reset clears control state only.
`default_nettype none
module grid_min_path_sum (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [gmps_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic [15:0]                   cell_cost,
	input  wire logic                          last_cell,
	output      logic                          done,
	output      logic [gmps_pkg::SUM_W-1:0]    path_sum
);
	localparam int DIM_W   = gmps_pkg::DIM_W;
	localparam int CNT_W   = gmps_pkg::CNT_W;
	localparam int CELL_W  = gmps_pkg::CELL_W;
	localparam int HCNT_W  = gmps_pkg::HCNT_W;
	localparam int HADDR_W = gmps_pkg::HADDR_W;
	localparam int SUM_W   = gmps_pkg::SUM_W;

	gmps_pkg::state_t state_q, state_d;

	logic [gmps_pkg::CFG_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0]           load_q, clr_q, n_q, n_cur;
	logic [DIM_W-1:0]           nr, nc, nr_q, nc_q;
	logic [HCNT_W-1:0]          hcnt_q, i_q;
	logic [HCNT_W:0]            lidx, ridx;
	logic [HCNT_W-1:0]          pidx;
	gmps_pkg::entry_t           val_q, top_q, lv_q, nb_q, nb, child;
	logic                       rok_q, nb_ok, rsel, swap, upd, up_swap;
	logic [1:0]                 k_q;
	logic [SUM_W-1:0]           nd;

	logic                               c_we;
	logic [CELL_W-1:0]                  c_raddr;
	logic [gmps_pkg::COST_WIDTH-1:0]    c_rd;
	logic                               b_we;
	logic [CELL_W-1:0]                  b_waddr, b_raddr;
	gmps_pkg::best_t                    b_wdata, b_rd;
	logic                               h_we;
	logic [HADDR_W-1:0]                 h_waddr, h_raddr;
	gmps_pkg::entry_t                   h_wdata, h_rd;

	gmps_ram #(.WIDTH(gmps_pkg::COST_WIDTH), .DEPTH(gmps_pkg::CELLS)) u_cost (
		.clk   (clk),
		.we    (c_we),
		.waddr (load_q[CELL_W-1:0]),
		.wdata (gmps_pkg::COST_WIDTH'(cell_cost)),
		.raddr (c_raddr),
		.rdata (c_rd)
	);

	gmps_ram #(.WIDTH($bits(gmps_pkg::best_t)), .DEPTH(gmps_pkg::CELLS)) u_best (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	gmps_ram #(.WIDTH($bits(gmps_pkg::entry_t)), .DEPTH(gmps_pkg::HEAP_DEPTH)) u_heap (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rd)
	);

	always_comb begin
		if (rows_q == '0) begin
			nr = DIM_W'(1);
		end else if (int'(rows_q) > gmps_pkg::MAX_ROWS) begin
			nr = DIM_W'(gmps_pkg::MAX_ROWS);
		end else begin
			nr = DIM_W'(rows_q);
		end
		if (cols_q == '0) begin
			nc = DIM_W'(1);
		end else if (int'(cols_q) > gmps_pkg::MAX_COLS) begin
			nc = DIM_W'(gmps_pkg::MAX_COLS);
		end else begin
			nc = DIM_W'(cols_q);
		end
	end

	assign n_cur = CNT_W'(nr) * CNT_W'(nc);
	assign lidx  = {i_q, 1'b1};
	assign ridx  = lidx + (HCNT_W+1)'(1);
	assign pidx  = (i_q - HCNT_W'(1)) >> 1;

	// neighbor k: down, up, right, left
	always_comb begin
		nb     = top_q;
		nb_ok  = 1'b0;
		case (k_q)
			2'd0: begin
				nb_ok   = (DIM_W'(top_q.row) + DIM_W'(1)) < nr_q;
				nb.idx  = top_q.idx + CELL_W'(nc_q);
				nb.row  = top_q.row + gmps_pkg::ROW_W'(1);
			end
			2'd1: begin
				nb_ok   = top_q.row != '0;
				nb.idx  = top_q.idx - CELL_W'(nc_q);
				nb.row  = top_q.row - gmps_pkg::ROW_W'(1);
			end
			2'd2: begin
				nb_ok   = (DIM_W'(top_q.col) + DIM_W'(1)) < nc_q;
				nb.idx  = top_q.idx + CELL_W'(1);
				nb.col  = top_q.col + gmps_pkg::COL_W'(1);
			end
			default: begin
				nb_ok   = top_q.col != '0;
				nb.idx  = top_q.idx - CELL_W'(1);
				nb.col  = top_q.col - gmps_pkg::COL_W'(1);
			end
		endcase
	end

	assign rsel    = rok_q && ({h_rd.key, h_rd.idx} < {lv_q.key, lv_q.idx});
	assign child   = rsel ? h_rd : lv_q;
	assign swap    = {child.key, child.idx} < {val_q.key, val_q.idx};
	assign nd      = top_q.key + SUM_W'(c_rd);
	assign upd     = !b_rd.seen || (nd < b_rd.sum);
	assign up_swap = {val_q.key, val_q.idx} < {h_rd.key, h_rd.idx};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gmps_pkg::ST_IDLE:   if (start && last_cell) state_d = gmps_pkg::ST_CLEAR;
			gmps_pkg::ST_CLEAR:  if (clr_q == n_q - CNT_W'(1)) state_d = gmps_pkg::ST_INIT;
			gmps_pkg::ST_INIT:   state_d = gmps_pkg::ST_SEED;
			gmps_pkg::ST_SEED:   state_d = gmps_pkg::ST_POP0;
			gmps_pkg::ST_POP0:   state_d = (hcnt_q == '0) ? gmps_pkg::ST_DONE : gmps_pkg::ST_POP1;
			gmps_pkg::ST_POP1:   state_d = gmps_pkg::ST_POP2;
			gmps_pkg::ST_POP2:   state_d = (hcnt_q == '0) ? gmps_pkg::ST_CHECK
			                                               : gmps_pkg::ST_SIFT_L;
			gmps_pkg::ST_SIFT_L: state_d = (lidx >= {1'b0, hcnt_q}) ? gmps_pkg::ST_CHECK
			                                                        : gmps_pkg::ST_SIFT_R;
			gmps_pkg::ST_SIFT_R: state_d = gmps_pkg::ST_SIFT_C;
			gmps_pkg::ST_SIFT_C: state_d = swap ? gmps_pkg::ST_SIFT_L : gmps_pkg::ST_CHECK;
			gmps_pkg::ST_CHECK:  state_d = gmps_pkg::ST_EXPAND;
			gmps_pkg::ST_EXPAND: state_d = (top_q.key > b_rd.sum) ? gmps_pkg::ST_POP0
			                                                       : gmps_pkg::ST_NB;
			gmps_pkg::ST_NB: begin
				if (nb_ok) begin
					state_d = gmps_pkg::ST_RELAX;
				end else if (k_q == 2'd3) begin
					state_d = gmps_pkg::ST_POP0;
				end
			end
			gmps_pkg::ST_RELAX: begin
				if (upd) begin
					state_d = gmps_pkg::ST_UP;
				end else begin
					state_d = (k_q == 2'd3) ? gmps_pkg::ST_POP0 : gmps_pkg::ST_NB;
				end
			end
			gmps_pkg::ST_UP: begin
				if (i_q != '0) begin
					state_d = gmps_pkg::ST_UP_C;
				end else begin
					state_d = (k_q == 2'd3) ? gmps_pkg::ST_POP0 : gmps_pkg::ST_NB;
				end
			end
			gmps_pkg::ST_UP_C: begin
				if (up_swap) begin
					state_d = gmps_pkg::ST_UP;
				end else begin
					state_d = (k_q == 2'd3) ? gmps_pkg::ST_POP0 : gmps_pkg::ST_NB;
				end
			end
			gmps_pkg::ST_DONE:   state_d = gmps_pkg::ST_IDLE;
			default:             state_d = gmps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy    = state_q != gmps_pkg::ST_IDLE;
		done    = state_q == gmps_pkg::ST_DONE;
		c_we    = 1'b0;
		c_raddr = '0;
		b_we    = 1'b0;
		b_waddr = '0;
		b_wdata = '0;
		b_raddr = '0;
		h_we    = 1'b0;
		h_waddr = '0;
		h_wdata = val_q;
		h_raddr = '0;
		unique case (state_q)
			gmps_pkg::ST_IDLE:  c_we = start && (load_q < n_cur);
			gmps_pkg::ST_CLEAR: begin
				b_we    = 1'b1;
				b_waddr = clr_q[CELL_W-1:0];
			end
			gmps_pkg::ST_INIT:  c_raddr = '0;
			gmps_pkg::ST_SEED: begin
				b_we         = 1'b1;
				b_wdata.seen = 1'b1;
				b_wdata.sum  = SUM_W'(c_rd);
				h_we         = 1'b1;
				h_wdata      = '0;
				h_wdata.key  = SUM_W'(c_rd);
			end
			gmps_pkg::ST_POP0: begin
				h_raddr = '0;
				b_raddr = CELL_W'(n_q - CNT_W'(1));
			end
			gmps_pkg::ST_POP1:  h_raddr = HADDR_W'(hcnt_q - HCNT_W'(1));
			gmps_pkg::ST_POP2:  h_raddr = '0;
			gmps_pkg::ST_SIFT_L: begin
				if (lidx >= {1'b0, hcnt_q}) begin
					h_we    = 1'b1;
					h_waddr = HADDR_W'(i_q);
				end else begin
					h_raddr = HADDR_W'(lidx);
				end
			end
			gmps_pkg::ST_SIFT_R: h_raddr = HADDR_W'(ridx);
			gmps_pkg::ST_SIFT_C: begin
				h_we    = 1'b1;
				h_waddr = HADDR_W'(i_q);
				h_wdata = swap ? child : val_q;
			end
			gmps_pkg::ST_CHECK:  b_raddr = top_q.idx;
			gmps_pkg::ST_EXPAND: b_raddr = top_q.idx;
			gmps_pkg::ST_NB: begin
				c_raddr = nb.idx;
				b_raddr = nb.idx;
			end
			gmps_pkg::ST_RELAX: begin
				b_we         = upd;
				b_waddr      = nb_q.idx;
				b_wdata.seen = 1'b1;
				b_wdata.sum  = nd;
			end
			gmps_pkg::ST_UP: begin
				if (i_q == '0) begin
					h_we    = 1'b1;
					h_waddr = '0;
				end else begin
					h_raddr = HADDR_W'(pidx);
				end
			end
			gmps_pkg::ST_UP_C: begin
				h_we    = 1'b1;
				h_waddr = HADDR_W'(i_q);
				h_wdata = up_swap ? h_rd : val_q;
			end
			gmps_pkg::ST_DONE: b_raddr = CELL_W'(n_q - CNT_W'(1));
			default: ;
		endcase
	end

	assign path_sum = b_rd.sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmps_pkg::ST_IDLE;
			rows_q  <= gmps_pkg::CFG_W'(1);
			cols_q  <= gmps_pkg::CFG_W'(1);
			load_q  <= '0;
			hcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					gmps_pkg::REG_ROWS: rows_q <= cfg_data;
					gmps_pkg::REG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				gmps_pkg::ST_IDLE: if (start && (load_q < n_cur)) load_q <= load_q + CNT_W'(1);
				gmps_pkg::ST_SEED: hcnt_q <= HCNT_W'(1);
				gmps_pkg::ST_POP1: hcnt_q <= hcnt_q - HCNT_W'(1);
				gmps_pkg::ST_RELAX: if (upd) hcnt_q <= hcnt_q + HCNT_W'(1);
				gmps_pkg::ST_DONE: load_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gmps_pkg::ST_IDLE: begin
				nr_q  <= nr;
				nc_q  <= nc;
				n_q   <= n_cur;
				clr_q <= '0;
			end
			gmps_pkg::ST_CLEAR: clr_q <= clr_q + CNT_W'(1);
			gmps_pkg::ST_POP1:  top_q <= h_rd;
			gmps_pkg::ST_POP2: begin
				val_q <= h_rd;
				i_q   <= '0;
			end
			gmps_pkg::ST_SIFT_R: begin
				lv_q  <= h_rd;
				rok_q <= ridx < {1'b0, hcnt_q};
			end
			gmps_pkg::ST_SIFT_C: if (swap) i_q <= rsel ? HCNT_W'(ridx) : HCNT_W'(lidx);
			gmps_pkg::ST_EXPAND: k_q <= 2'd0;
			gmps_pkg::ST_NB: begin
				nb_q <= nb;
				if (!nb_ok) k_q <= k_q + 2'd1;
			end
			gmps_pkg::ST_RELAX: begin
				if (upd) begin
					val_q <= {nd, nb_q.idx, nb_q.row, nb_q.col};
					i_q   <= hcnt_q;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			gmps_pkg::ST_UP: if (i_q == '0) k_q <= k_q + 2'd1;
			gmps_pkg::ST_UP_C: begin
				if (up_swap) begin
					i_q <= pidx;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(hcnt_q) <= gmps_pkg::HEAP_DEPTH)
		else $error("heap count beyond depth");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_cell) |=> busy)
		else $error("search did not start on last item");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gmps_pkg::ST_POP1) |-> (hcnt_q != '0))
		else $error("pop from empty heap");
`endif

endmodule
`default_nettype wire

// ===== dv/grid_min_path_sum_test.sv =====
// ----------------------------------------------------------------------------
// grid_min_path_sum_test: self-checking bench for the grid path search
// Loads grids of random and extreme cell costs under several row and column
// settings, predicts each cheapest path sum and checks every done strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module grid_min_path_sum_test;

	localparam int LIMIT = 20000000;

	typedef struct {
		logic [15:0] cost;
		logic        last;
	} cell_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic                          cfg_index = gmps_pkg::REG_ROWS;
	logic [gmps_pkg::CFG_W-1:0]    cfg_data = '0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [15:0]                   cell_cost = '0;
	logic                          last_cell = 1'b0;
	logic                          done;
	logic [gmps_pkg::SUM_W-1:0]    path_sum;

	cell_item_t                    pending[$];
	logic [gmps_pkg::SUM_W-1:0]    sums_due[$];
	int                            errors = 0;
	int                            cycles = 0;
	int                            items_taken = 0;
	int                            searches = 0;
	int                            gap = 0;

	// predictor state
	int                            cfg_rows = 1;
	int                            cfg_cols = 1;
	longint                        cell_costs[gmps_pkg::CELLS];
	longint                        best_sum[gmps_pkg::CELLS];
	bit                            fixed[gmps_pkg::CELLS];
	int                            load_pos = 0;

	// generator view of the loaded store
	int                            gen_pos = 0;
	int                            written = 0;
	int                            grids = 0;

	grid_min_path_sum DUT (.*);

	always #4 clk = ~clk;

	function automatic int clamp_dim(int v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic logic [gmps_pkg::SUM_W-1:0] cheapest_path(int nr, int nc);
		int n;
		int u;
		int v;
		longint nd;
		n = nr * nc;
		for (int i = 0; i < n; i++) begin
			best_sum[i] = -1;
			fixed[i] = 1'b0;
		end
		best_sum[0] = cell_costs[0];
		for (int k = 0; k < n; k++) begin
			u = -1;
			for (int i = 0; i < n; i++)
				if (!fixed[i] && best_sum[i] >= 0 && (u < 0 || best_sum[i] < best_sum[u]))
					u = i;
			if (u < 0) break;
			fixed[u] = 1'b1;
			for (int d = 0; d < 4; d++) begin
				v = -1;
				case (d)
					0: if (u / nc + 1 < nr) v = u + nc;
					1: if (u / nc > 0) v = u - nc;
					2: if (u % nc + 1 < nc) v = u + 1;
					3: if (u % nc > 0) v = u - 1;
				endcase
				if (v >= 0 && !fixed[v]) begin
					nd = best_sum[u] + cell_costs[v];
					if (best_sum[v] < 0 || nd < best_sum[v]) best_sum[v] = nd;
				end
			end
		end
		return best_sum[n-1][gmps_pkg::SUM_W-1:0];
	endfunction

	// driver
	always @(posedge clk) begin
		int nr;
		int nc;
		cell_item_t it;
		logic took;
		if (arst_n) begin
			took = start && !busy;
			if (took) begin
				nr = clamp_dim(cfg_rows, gmps_pkg::MAX_ROWS);
				nc = clamp_dim(cfg_cols, gmps_pkg::MAX_COLS);
				items_taken++;
				if (load_pos < nr * nc) begin
					cell_costs[load_pos] = cell_cost;
					load_pos++;
				end
				if (last_cell) begin
					sums_due.insert(sums_due.size(), cheapest_path(nr, nc));
					load_pos = 0;
				end
			end
			if (!start || took) begin
				if (gap > 0) begin
					gap <= gap - 1;
					start <= 1'b0;
				end else if (pending.size() > 0) begin
					it = pending.pop_front();
					cell_cost <= it.cost;
					last_cell <= it.last;
					start <= 1'b1;
					gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [gmps_pkg::SUM_W-1:0] want;
		cycles++;
		if (arst_n && done) begin
			if (sums_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected path_sum %0d", path_sum);
			end else begin
				want = sums_due.pop_front();
				searches++;
				if (path_sum !== want) begin
					errors++;
					if (errors <= 10)
						$display("path_sum mismatch: expected %0d, got %0d", want, path_sum);
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [15:0] pick_cost();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// queue one grid; early>0 ends after that many cells, extra adds ignored cells
	task automatic add_grid(int early, int extra, bit fixed_cost, logic [15:0] cval);
		int n;
		int k;
		cell_item_t it;
		n = clamp_dim(cfg_rows, gmps_pkg::MAX_ROWS) * clamp_dim(cfg_cols, gmps_pkg::MAX_COLS);
		k = (early > 0) ? early : n + extra;
		for (int i = 0; i < k; i++) begin
			it.cost = fixed_cost ? cval : pick_cost();
			it.last = (i == k - 1);
			pending.insert(pending.size(), it);
		end
		if (k > written) written = (k > n) ? ((n > written) ? n : written) : k;
		grids++;
	endtask

	task automatic settle();
		while (pending.size() > 0 || start || gap > 0 || sums_due.size() > 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_dims(int r, int c);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= gmps_pkg::REG_ROWS;
		cfg_data <= gmps_pkg::CFG_W'(r);
		@(posedge clk);
		cfg_index <= gmps_pkg::REG_COLS;
		cfg_data <= gmps_pkg::CFG_W'(c);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_rows = r;
		cfg_cols = c;
	endtask

	initial begin
		int n;
		int r;
		int c;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		add_grid(0, 0, 1'b1, 16'hFFFF);
		add_grid(0, 2, 1'b1, 16'h0000);
		set_dims(2, 2);
		add_grid(0, 0, 1'b1, 16'hFFFF);
		add_grid(0, 3, 1'b0, 16'h0);
		set_dims(3, 3);
		add_grid(0, 0, 1'b0, 16'h0);
		add_grid(4, 0, 1'b0, 16'h0);
		set_dims(0, 255);
		add_grid(0, 0, 1'b0, 16'h0);
		set_dims(255, 0);
		add_grid(0, 1, 1'b0, 16'h0);

		// random
		while (items_taken + pending.size() < 1800) begin
			case ($urandom_range(0, 9))
				0: begin r = $urandom_range(0, 1) ? 0 : 255; c = $urandom_range(1, 3); end
				1: begin r = $urandom_range(1, 3); c = $urandom_range(0, 1) ? 0 : 128; end
				default: begin r = $urandom_range(1, 8); c = $urandom_range(1, 8); end
			endcase
			set_dims(r, c);
			written = 0;
			add_grid(0, 0, 1'b0, 16'h0);
			n = clamp_dim(r, gmps_pkg::MAX_ROWS) * clamp_dim(c, gmps_pkg::MAX_COLS);
			for (int g = $urandom_range(1, 4);
			     g > 0 && items_taken + pending.size() < 1800; g--) begin
				case ($urandom_range(0, 7))
					0: add_grid(0, $urandom_range(1, 4), 1'b0, 16'h0);
					1: add_grid($urandom_range(1, n), 0, 1'b0, 16'h0);
					default: add_grid(0, 0, 1'b0, 16'h0);
				endcase
			end
		end

		settle();
		repeat (20) @(posedge clk);
		$display("%0d items loaded into %0d grids, %0d searches checked, %0d errors",
			items_taken, grids, searches, errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
